/* hdl/drb_pkg.sv */
`default_nettype none
package drb_pkg;

    // storage geometry
    localparam int WORDS     = 4;
    localparam int WORD_BITS = 64;
    localparam int CAP       = WORDS * WORD_BITS;
    localparam int IDX_W     = $clog2(WORDS);
    localparam int POS_W     = 9;
    localparam int GIDX_W    = POS_W + 1;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);

    // operation codes
    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_RANK   = 3'd2;
    localparam logic [2:0] OP_RRANK  = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;
    localparam logic [2:0] OP_ERASE  = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;
    // unused code, leaves everything as it is
    localparam logic [2:0] OP_NOP    = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RECOUNT
    } t_state;

    // ones in one word
    function automatic logic [CNT_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            c = c + CNT_W'(v[b]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* hdl/dynamic_rank_bitvector.sv */
// channel      direction  signals
// command      in         start, busy, i_op, i_position, i_end_position, i_bit_value, i_amount
// result       out        o_valid, o_bit_out, o_ones_count, o_length, o_overflow
// config       in         i_cfg_we, i_cfg_data
//
// get, clear and the unused code give their result in the cycle after start is accepted.
// set gives its result in the cycle after start when the bit is unchanged, and runs a recount when the bit changes.
// rank and range rank walk the stored words, one stored word per cycle through one popcount unit.
// insert and erase move the stored words through one funnel shifter, then recount them.
// reset is synchronous active low and clears the vector and the length.
// busy stays high until the result strobe; the receiver cannot stall.
`default_nettype none
module dynamic_rank_bitvector (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [2:0]                  i_op,
    input  wire logic [drb_pkg::POS_W-1:0]   i_position,
    input  wire logic [drb_pkg::POS_W-1:0]   i_end_position,
    input  wire logic                        i_bit_value,
    input  wire logic [drb_pkg::POS_W-1:0]   i_amount,
    input  wire logic                        i_cfg_we,
    input  wire logic [drb_pkg::POS_W-1:0]   i_cfg_data,
    output logic                             o_valid,
    output logic                             o_bit_out,
    output logic [drb_pkg::POS_W-1:0]        o_ones_count,
    output logic [drb_pkg::POS_W-1:0]        o_length,
    output logic                             o_overflow
);

    localparam int WB  = drb_pkg::WORD_BITS;
    localparam int GW  = drb_pkg::GIDX_W;
    localparam int PW  = drb_pkg::POS_W;
    localparam int IW  = drb_pkg::IDX_W;
    localparam int BW  = GW + 2;

    drb_pkg::t_state r_state, n_state;

    logic [WB-1:0]                 r_words [drb_pkg::WORDS];
    logic [drb_pkg::CNT_W-1:0]     r_word_ones [drb_pkg::WORDS];
    logic [PW-1:0]                 r_bit_length;
    logic [PW-1:0]                 r_init_len;

    logic [2:0]                    r_op;
    logic [PW-1:0]                 r_pos;
    logic [GW-1:0]                 r_lo, r_hi, r_zlim;
    logic signed [BW-1:0]          r_delta;
    logic [IW-1:0]                 r_cnt, n_cnt;
    logic                          r_valid, n_valid;
    logic                          r_bit_out, r_ovf;
    logic [PW-1:0]                 r_ones;

    logic                          accept;
    logic                          last;
    logic [IW-1:0]                 widx;
    logic [GW-1:0]                 wbase;
    logic signed [BW-1:0]          sbase;
    logic signed [BW-7:0]          sk;
    logic signed [BW-6:0]          sk1;
    logic [5:0]                    sh;
    logic [WB-1:0]                 hiw, low;
    logic [2*WB-1:0]               cat;
    logic [WB-1:0]                 shf, new_word, rmask, pop_in;
    logic [drb_pkg::CNT_W-1:0]     pop;
    logic [GW-1:0]                 g;

    // accept-time decode
    logic                          in_cap;
    logic [GW-1:0]                 endc, posc;
    logic [GW-1:0]                 ins_sum;
    logic [GW-1:0]                 ers_n;
    logic                          set_hit;
    logic                          ins_go, ers_go;

    assign accept = start && !busy;
    assign busy   = (r_state != drb_pkg::ST_IDLE);
    assign last   = (r_cnt == IW'(drb_pkg::WORDS - 1));

    assign in_cap  = ({1'b0, i_position} < GW'(drb_pkg::CAP));
    assign posc    = in_cap ? {1'b0, i_position} : GW'(drb_pkg::CAP);
    assign endc    = ({1'b0, i_end_position} > GW'(drb_pkg::CAP)) ? GW'(drb_pkg::CAP)
                                                                  : {1'b0, i_end_position};
    assign ins_sum = {1'b0, r_bit_length} + {1'b0, i_amount};
    assign ers_n   = endc - posc;
    assign ins_go  = in_cap && (i_amount != '0);
    assign ers_go  = in_cap && (endc > posc);
    assign set_hit = in_cap &&
        (r_words[i_position[IW+5:6]][6'(WB - 1) - i_position[5:0]] != i_bit_value);

    // word walked this cycle: insert goes from the top down
    assign widx  = (r_op == drb_pkg::OP_INSERT) ? IW'(drb_pkg::WORDS - 1) - r_cnt : r_cnt;
    assign wbase = GW'({widx, 6'b0});

    // funnel shifter over two neighboring source words
    assign sbase = $signed({2'b00, wbase}) + r_delta;
    assign sk    = sbase[BW-1:6];
    assign sk1   = (BW-5)'(sk) + (BW-5)'(1);
    assign sh    = sbase[5:0];
    assign hiw   = (sk >= 0 && sk < (BW-6)'(drb_pkg::WORDS)) ? r_words[sk[IW-1:0]] : '0;
    assign low   = (sk1 >= 0 && sk1 < (BW-5)'(drb_pkg::WORDS)) ? r_words[sk1[IW-1:0]] : '0;
    assign cat   = {hiw, low} << sh;
    assign shf   = cat[2*WB-1:WB];

    // per-bit merge and rank window
    always_comb begin
        new_word = '0;
        rmask    = '0;
        g        = '0;
        for (int j = 0; j < WB; j++) begin
            g = wbase + GW'(j);
            if (g < {1'b0, r_pos}) begin
                new_word[WB-1-j] = r_words[widx][WB-1-j];
            end else if (g < r_zlim) begin
                new_word[WB-1-j] = 1'b0;
            end else begin
                new_word[WB-1-j] = shf[WB-1-j];
            end
            rmask[WB-1-j] = (g >= r_lo) && (g < r_hi);
        end
    end

    // shared popcount unit
    assign pop_in = (r_state == drb_pkg::ST_WALK) ? (r_words[widx] & rmask) : r_words[r_cnt];
    assign pop    = drb_pkg::popcount(pop_in);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        unique case (r_state)
            drb_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    case (i_op)
                        drb_pkg::OP_SET: begin
                            if (set_hit) n_state = drb_pkg::ST_RECOUNT;
                            else n_valid = 1'b1;
                        end
                        drb_pkg::OP_RANK, drb_pkg::OP_RRANK: begin
                            n_state = drb_pkg::ST_WALK;
                        end
                        drb_pkg::OP_INSERT: begin
                            if (ins_go) n_state = drb_pkg::ST_WALK;
                            else n_valid = 1'b1;
                        end
                        drb_pkg::OP_ERASE: begin
                            if (ers_go) n_state = drb_pkg::ST_WALK;
                            else n_valid = 1'b1;
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            drb_pkg::ST_WALK: begin
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    if (r_op == drb_pkg::OP_INSERT || r_op == drb_pkg::OP_ERASE) begin
                        n_state = drb_pkg::ST_RECOUNT;
                    end else begin
                        n_state = drb_pkg::ST_IDLE;
                        n_valid = 1'b1;
                    end
                end
            end
            drb_pkg::ST_RECOUNT: begin
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_state = drb_pkg::ST_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: n_state = drb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drb_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // storage, length and transaction registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < drb_pkg::WORDS; w++) begin
                r_words[w]     <= '0;
                r_word_ones[w] <= '0;
            end
            r_bit_length <= '0;
            r_init_len   <= '0;
        end else begin
            if (i_cfg_we) r_init_len <= i_cfg_data;
            if (accept) begin
                r_op      <= i_op;
                r_pos     <= posc[PW-1:0];
                r_bit_out <= 1'b0;
                r_ones    <= '0;
                r_ovf     <= 1'b0;
                r_zlim    <= posc;
                r_lo      <= '0;
                r_hi      <= posc;
                r_delta   <= '0;
                case (i_op)
                    drb_pkg::OP_GET: begin
                        r_bit_out <= in_cap &&
                            r_words[i_position[IW+5:6]][6'(WB - 1) - i_position[5:0]];
                    end
                    drb_pkg::OP_SET: begin
                        if (set_hit) begin
                            r_bit_out <= 1'b1;
                            r_words[i_position[IW+5:6]][6'(WB - 1) - i_position[5:0]]
                                <= i_bit_value;
                        end
                    end
                    drb_pkg::OP_RRANK: begin
                        r_lo <= posc;
                        r_hi <= endc;
                    end
                    drb_pkg::OP_INSERT: begin
                        r_zlim  <= posc + {1'b0, i_amount};
                        r_delta <= -$signed(BW'({1'b0, i_amount}));
                        if (ins_sum > GW'(drb_pkg::CAP)) begin
                            r_bit_length <= PW'(drb_pkg::CAP);
                            r_ovf        <= 1'b1;
                        end else begin
                            r_bit_length <= ins_sum[PW-1:0];
                        end
                    end
                    drb_pkg::OP_ERASE: begin
                        r_delta <= $signed(BW'(ers_n));
                        if (ers_go) begin
                            r_bit_length <= ({1'b0, r_bit_length} > ers_n)
                                ? PW'({1'b0, r_bit_length} - ers_n) : '0;
                        end
                    end
                    drb_pkg::OP_CLEAR: begin
                        for (int w = 0; w < drb_pkg::WORDS; w++) begin
                            r_words[w]     <= '0;
                            r_word_ones[w] <= '0;
                        end
                        r_bit_length <= ({1'b0, r_init_len} > GW'(drb_pkg::CAP))
                            ? PW'(drb_pkg::CAP) : r_init_len;
                    end
                    default: ;
                endcase
            end
            if (r_state == drb_pkg::ST_WALK) begin
                if (r_op == drb_pkg::OP_INSERT || r_op == drb_pkg::OP_ERASE) begin
                    r_words[widx] <= new_word;
                end else begin
                    r_ones <= r_ones + PW'(pop);
                end
            end
            if (r_state == drb_pkg::ST_RECOUNT) begin
                r_word_ones[r_cnt] <= pop;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_bit_out    = r_bit_out;
    assign o_ones_count = r_ones;
    assign o_length     = r_bit_length;
    assign o_overflow   = r_ovf;

    // result strobe only when the sequencer is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result strobe while busy");

    // a read gives its result in the cycle after it is accepted
    a_get_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == drb_pkg::OP_GET) |=> o_valid) else $error("get result missing");

    // length never passes capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_bit_length} <= GW'(drb_pkg::CAP)) else $error("length beyond capacity");

    // recount only after a data change
    a_recount_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drb_pkg::ST_RECOUNT) |-> (r_op == drb_pkg::OP_SET ||
        r_op == drb_pkg::OP_INSERT || r_op == drb_pkg::OP_ERASE))
        else $error("recount for wrong operation");

endmodule
`default_nettype wire

/* bench/tb_dynamic_rank_bitvector.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_dynamic_rank_bitvector;

    localparam int CAP       = drb_pkg::CAP;
    localparam int POS_W     = drb_pkg::POS_W;
    localparam int CLR_LIMIT = (CAP < 511) ? CAP : 511;

    typedef struct packed {
        logic [2:0]       op;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] endp;
        logic             bval;
        logic [POS_W-1:0] amt;
    } t_cmd;

    typedef struct packed {
        logic             bit_out;
        logic [POS_W-1:0] ones;
        logic [POS_W-1:0] len;
        logic             ovf;
    } t_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [2:0]       i_op = '0;
    logic [POS_W-1:0] i_position = '0;
    logic [POS_W-1:0] i_end_position = '0;
    logic             i_bit_value = 1'b0;
    logic [POS_W-1:0] i_amount = '0;
    logic             i_cfg_we = 1'b0;
    logic [POS_W-1:0] i_cfg_data = '0;
    logic             o_valid;
    logic             o_bit_out;
    logic [POS_W-1:0] o_ones_count;
    logic [POS_W-1:0] o_length;
    logic             o_overflow;

    dynamic_rank_bitvector i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_position(i_position), .i_end_position(i_end_position),
        .i_bit_value(i_bit_value), .i_amount(i_amount),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_bit_out(o_bit_out), .o_ones_count(o_ones_count),
        .o_length(o_length), .o_overflow(o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the vector, bit 0 of the vector is bits[0]
    logic [CAP-1:0]   bits;
    logic [POS_W-1:0] vec_len;
    logic [POS_W-1:0] clear_len;
    t_cmd             cmd_q[$];
    t_res             result_q[$];
    int               n_err = 0;
    bit               calm = 0;
    bit               pace = 1;

    function automatic int ones_below(int p);
        int c;
        c = 0;
        if (p > CAP) p = CAP;
        for (int i = 0; i < p; i++) c += bits[i];
        return c;
    endfunction

    // compute the result of one transaction and update the shadow vector
    function automatic t_res apply_cmd(t_cmd c);
        t_res r;
        logic [CAP-1:0] nb;
        int len;
        int e;
        int n;
        r = '0;
        case (c.op)
            drb_pkg::OP_GET: r.bit_out = (c.pos < CAP) ? bits[c.pos] : 1'b0;
            drb_pkg::OP_SET: if (c.pos < CAP && bits[c.pos] != c.bval) begin
                bits[c.pos] = c.bval;
                r.bit_out = 1'b1;
            end
            drb_pkg::OP_RANK: r.ones = POS_W'(ones_below(c.pos));
            drb_pkg::OP_RRANK: if (c.endp > c.pos)
                r.ones = POS_W'(ones_below(c.endp) - ones_below(c.pos));
            drb_pkg::OP_INSERT: begin
                if (c.pos < CAP && c.amt != 0) begin
                    nb = bits;
                    for (int d = c.pos; d < CAP; d++)
                        nb[d] = (d >= c.pos + c.amt) ? bits[d - c.amt] : 1'b0;
                    bits = nb;
                end
                len = vec_len + c.amt;
                if (len > CLR_LIMIT) begin
                    len = CLR_LIMIT;
                    r.ovf = 1'b1;
                end
                vec_len = POS_W'(len);
            end
            drb_pkg::OP_ERASE: begin
                e = (c.endp > CAP) ? CAP : c.endp;
                if (c.pos < CAP && e > c.pos) begin
                    n = e - c.pos;
                    nb = bits;
                    for (int i = c.pos; i < CAP; i++)
                        nb[i] = (i + n < CAP) ? bits[i + n] : 1'b0;
                    bits = nb;
                    vec_len = (vec_len > n) ? POS_W'(vec_len - n) : '0;
                end
            end
            drb_pkg::OP_CLEAR: begin
                bits = '0;
                vec_len = (clear_len > CLR_LIMIT) ? POS_W'(CLR_LIMIT) : clear_len;
            end
            default: ;
        endcase
        r.len = vec_len;
        return r;
    endfunction

    // driver: pops commands and holds start until accepted
    always @(posedge i_clk) begin
        t_cmd c;
        if (!i_rst_n || !pace) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
            c = cmd_q.pop_front();
            result_q.push_back(apply_cmd(c));
            start <= 1'b1;
            i_op <= c.op;
            i_position <= c.pos;
            i_end_position <= c.endp;
            i_bit_value <= c.bval;
            i_amount <= c.amt;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: checks each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_res x;
        if (i_rst_n && o_valid) begin
            if (result_q.size() == 0) begin
                $error("unexpected result transaction");
                n_err++;
            end else begin
                x = result_q.pop_front();
                if (o_bit_out !== x.bit_out) begin
                    $error("bit_out exp %0d got %0d", x.bit_out, o_bit_out); n_err++;
                end
                if (o_ones_count !== x.ones) begin
                    $error("ones_count exp %0d got %0d", x.ones, o_ones_count); n_err++;
                end
                if (o_length !== x.len) begin
                    $error("length exp %0d got %0d", x.len, o_length); n_err++;
                end
                if (o_overflow !== x.ovf) begin
                    $error("overflow exp %0d got %0d", x.ovf, o_overflow); n_err++;
                end
            end
        end
    end

    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(5))
            0: return POS_W'($urandom_range(511));
            1: return POS_W'($urandom_range(CAP));
            2: return POS_W'(64 * $urandom_range(4) + $urandom_range(2) - 1);
            default: return POS_W'($urandom_range(CAP - 1));
        endcase
    endfunction

    task automatic add(input logic [2:0] op, input int p, input int e, input bit b,
                       input int a);
        t_cmd c;
        c.op = op; c.pos = POS_W'(p); c.endp = POS_W'(e); c.bval = b; c.amt = POS_W'(a);
        cmd_q.push_back(c);
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || result_q.size() > 0 || start) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_cfg(input int v);
        pace = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= POS_W'(v);
        clear_len = POS_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pace = 1;
    endtask

    // random mix that favors set to grow content
    task automatic random_batch(input int count);
        logic [2:0] op;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            op = (r < 30) ? drb_pkg::OP_SET : (r < 45) ? drb_pkg::OP_GET :
                 (r < 57) ? drb_pkg::OP_RANK : (r < 69) ? drb_pkg::OP_RRANK :
                 (r < 81) ? drb_pkg::OP_INSERT : (r < 93) ? drb_pkg::OP_ERASE :
                 (r < 97) ? drb_pkg::OP_CLEAR : drb_pkg::OP_NOP;
            add(op, pick_pos(), pick_pos(), $urandom_range(1),
                ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(40));
        end
    endtask

    initial begin
        bits = '0;
        vec_len = '0;
        clear_len = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: edges of every operation
        calm = 1;
        add(drb_pkg::OP_SET, 0, 0, 1, 0);
        add(drb_pkg::OP_SET, 63, 0, 1, 0);
        add(drb_pkg::OP_SET, 64, 0, 1, 0);
        add(drb_pkg::OP_SET, CAP - 1, 0, 1, 0);
        add(drb_pkg::OP_SET, CAP, 0, 1, 0);
        add(drb_pkg::OP_SET, 511, 0, 1, 0);
        add(drb_pkg::OP_SET, 0, 0, 1, 0);
        add(drb_pkg::OP_GET, CAP - 1, 0, 0, 0);
        add(drb_pkg::OP_GET, 511, 0, 0, 0);
        add(drb_pkg::OP_RANK, 511, 0, 0, 0);
        add(drb_pkg::OP_RANK, 64, 0, 0, 0);
        add(drb_pkg::OP_RRANK, 1, 511, 0, 0);
        add(drb_pkg::OP_RRANK, 100, 50, 0, 0);
        add(drb_pkg::OP_INSERT, 1, 0, 0, 70);
        add(drb_pkg::OP_INSERT, CAP, 0, 0, 511);
        add(drb_pkg::OP_INSERT, 0, 0, 0, 0);
        add(drb_pkg::OP_ERASE, 0, 511, 0, 0);
        add(drb_pkg::OP_SET, 5, 0, 1, 0);
        add(drb_pkg::OP_ERASE, 2, 2, 0, 0);
        add(drb_pkg::OP_ERASE, CAP, 511, 0, 0);
        add(drb_pkg::OP_ERASE, 0, 3, 0, 0);
        add(drb_pkg::OP_CLEAR, 0, 0, 0, 0);
        add(drb_pkg::OP_NOP, 511, 511, 1, 511);
        drain();

        // several clear lengths, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_cfg(511);
                1: write_cfg(0);
                2: write_cfg(CAP);
                3: write_cfg(257);
                default: write_cfg($urandom_range(511));
            endcase
            add(drb_pkg::OP_CLEAR, 0, 0, 0, 0);
            calm = (ph == 2);
            random_batch(300);
            drain();
        end

        if (n_err == 0 && result_q.size() == 0)
            $display("tb_dynamic_rank_bitvector: clean");
        else
            $display("tb_dynamic_rank_bitvector: errors");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb_dynamic_rank_bitvector: errors");
        $finish;
    end
endmodule
`default_nettype wire

/* dynamic_rank_bitvector.f */
hdl/drb_pkg.sv
hdl/dynamic_rank_bitvector.sv
bench/tb_dynamic_rank_bitvector.sv
